// ===== rtl/cubical_coface_enumerator_macros.svh =====
// Assertion macros for the cubical coface enumerator.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef CUBICAL_COFACE_ENUMERATOR_MACROS_SVH
`define CUBICAL_COFACE_ENUMERATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset
`define CCF_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, checked out of reset
`define CCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CCF_ASSERT_IMPLY(lbl, ante, cons)
`define CCF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/ccf_pkg.sv =====
// Shared constants, types and the candidate coface table.
// No dependencies.
package ccf_pkg;

  localparam int MAX_SIDE    = 32;
  localparam int PADDED      = MAX_SIDE + 2;
  localparam int STORE_DEPTH = PADDED * PADDED * PADDED;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CRD_W       = 6;
  localparam int SIZE_W      = 6;
  localparam int IDX_W       = 17;
  localparam int VAL_W       = 32;
  localparam int CFG_IDX_W   = 2;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

  // lowered axis of a candidate
  localparam logic [1:0] DEC_NONE = 2'd0;
  localparam logic [1:0] DEC_X    = 2'd1;
  localparam logic [1:0] DEC_Y    = 2'd2;
  localparam logic [1:0] DEC_Z    = 2'd3;

  // vox[k] = {x, y, z} padded offsets, two bits each
  typedef struct packed {
    logic [1:0]       dec;
    logic [1:0]       typ;
    logic [3:0][5:0]  vox;
  } cand_t;

  function automatic cand_t cand_rec(input logic [1:0] dec, input logic [1:0] typ,
                                     input logic [5:0] v0, input logic [5:0] v1,
                                     input logic [5:0] v2, input logic [5:0] v3);
    cand_t c;
    c.dec = dec;
    c.typ = typ;
    c.vox = {v3, v2, v1, v0};
    return c;
  endfunction

  function automatic logic [5:0] off(input int x, input int y, input int z);
    return {x[1:0], y[1:0], z[1:0]};
  endfunction

  // Fixed candidate order: six for points, four per edge type, two per face type
  function automatic cand_t cand_lookup(input logic [4:0] i);
    cand_t c;
    case (i)
      5'd0:  c = cand_rec(DEC_NONE, 2'd2, off(1,1,2), off(1,1,2), off(1,1,2), off(1,1,2));
      5'd1:  c = cand_rec(DEC_Z,    2'd2, off(1,1,0), off(1,1,0), off(1,1,0), off(1,1,0));
      5'd2:  c = cand_rec(DEC_NONE, 2'd1, off(1,2,1), off(1,2,1), off(1,2,1), off(1,2,1));
      5'd3:  c = cand_rec(DEC_Y,    2'd1, off(1,0,1), off(1,0,1), off(1,0,1), off(1,0,1));
      5'd4:  c = cand_rec(DEC_NONE, 2'd0, off(2,1,1), off(2,1,1), off(2,1,1), off(2,1,1));
      5'd5:  c = cand_rec(DEC_X,    2'd0, off(0,1,1), off(0,1,1), off(0,1,1), off(0,1,1));
      5'd6:  c = cand_rec(DEC_NONE, 2'd1, off(1,1,2), off(2,1,2), off(1,1,2), off(1,1,2));
      5'd7:  c = cand_rec(DEC_Z,    2'd1, off(1,1,0), off(2,1,0), off(1,1,0), off(1,1,0));
      5'd8:  c = cand_rec(DEC_NONE, 2'd0, off(1,2,1), off(2,2,1), off(1,2,1), off(1,2,1));
      5'd9:  c = cand_rec(DEC_Y,    2'd0, off(1,0,1), off(2,0,1), off(1,0,1), off(1,0,1));
      5'd10: c = cand_rec(DEC_NONE, 2'd2, off(1,1,2), off(1,2,2), off(1,1,2), off(1,1,2));
      5'd11: c = cand_rec(DEC_Z,    2'd2, off(1,1,0), off(1,2,0), off(1,1,0), off(1,1,0));
      5'd12: c = cand_rec(DEC_NONE, 2'd0, off(2,1,1), off(2,2,1), off(2,1,1), off(2,1,1));
      5'd13: c = cand_rec(DEC_X,    2'd0, off(0,1,1), off(0,2,1), off(0,1,1), off(0,1,1));
      5'd14: c = cand_rec(DEC_NONE, 2'd2, off(1,2,1), off(1,2,2), off(1,2,1), off(1,2,1));
      5'd15: c = cand_rec(DEC_Y,    2'd2, off(1,0,1), off(1,0,2), off(1,0,1), off(1,0,1));
      5'd16: c = cand_rec(DEC_NONE, 2'd1, off(2,1,1), off(2,1,2), off(2,1,1), off(2,1,1));
      5'd17: c = cand_rec(DEC_X,    2'd1, off(0,1,1), off(0,1,2), off(0,1,1), off(0,1,1));
      5'd18: c = cand_rec(DEC_NONE, 2'd0, off(1,1,2), off(2,1,2), off(1,2,2), off(2,2,2));
      5'd19: c = cand_rec(DEC_Z,    2'd0, off(1,1,0), off(2,1,0), off(1,2,0), off(2,2,0));
      5'd20: c = cand_rec(DEC_NONE, 2'd0, off(1,2,1), off(2,2,1), off(1,2,2), off(2,2,2));
      5'd21: c = cand_rec(DEC_Y,    2'd0, off(1,0,1), off(2,0,1), off(1,0,2), off(2,0,2));
      5'd22: c = cand_rec(DEC_NONE, 2'd0, off(2,1,1), off(2,2,1), off(2,1,2), off(2,2,2));
      5'd23: c = cand_rec(DEC_X,    2'd0, off(0,1,1), off(0,2,1), off(0,1,2), off(0,2,2));
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/ccf_div.sv =====
// Restoring divider, one quotient bit per cycle: index by a grid size.
// Depends on ccf_pkg.
module ccf_div import ccf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [IDX_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [IDX_W-1:0]  quo,
  output logic [SIZE_W-1:0] rem
);

  localparam int CNT_W = $clog2(IDX_W + 1);

  logic [IDX_W-1:0]  quo_r;
  logic [SIZE_W-1:0] rem_r;
  logic [SIZE_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              done_r;
  logic [SIZE_W:0]   trial;
  logic              ge;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[IDX_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        quo_r <= dividend;
        rem_r <= '0;
        dvs_r <= divisor;
      end else if (run_r) begin
        rem_r <= ge ? SIZE_W'(trial - {1'b0, dvs_r}) : SIZE_W'(trial);
        quo_r <= {quo_r[IDX_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(IDX_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/cubical_coface_enumerator.sv =====
// Coface enumerator over a padded 3-D voxel grid held in one on-chip memory.
// Write item: busy stays low. Query: three divisions to decode the index, the setup
// states S_BASE and S_SUM, then per candidate four voxel reads from the single
// memory port and an evaluation step, then the closing state S_FIN.
// Results are strobed one cycle each; the receiver cannot stall them.
// Reset (synchronous, rst_n low) resets control and config; voxel memory is not cleared.
`include "cubical_coface_enumerator_macros.svh"
module cubical_coface_enumerator import ccf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_operation,
  input  logic [CRD_W-1:0]         in_grid_x,
  input  logic [CRD_W-1:0]         in_grid_y,
  input  logic [CRD_W-1:0]         in_grid_z,
  input  logic signed [VAL_W-1:0]  in_voxel_value,
  input  logic [IDX_W-1:0]         in_cell_index,
  input  logic [1:0]               in_cell_dim,
  input  logic signed [VAL_W-1:0]  in_cell_value,
  output logic                     out_valid,
  output logic                     out_found,
  output logic [IDX_W-1:0]         out_coface_index,
  output logic [1:0]               out_coface_dim,
  output logic signed [VAL_W-1:0]  out_coface_value,
  output logic                     out_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [VAL_W-1:0]         cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_BASE = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;

  // configuration registers
  logic [SIZE_W-1:0]       size_x_r, size_y_r, size_z_r;
  logic signed [VAL_W-1:0] thr_r;

  // query context
  logic [SIZE_W-1:0]       sx_r, sy_r, sz_r;
  logic [11:0]             sxy_r;
  logic [IDX_W-1:0]        sxyz_r;
  logic [IDX_W-1:0]        idx_r;
  logic [1:0]              dim_r;
  logic signed [VAL_W-1:0] cval_r;
  logic [1:0]              phase_r;
  logic [SIZE_W-1:0]       cx_r, cy_r, cz_r;
  logic [IDX_W-1:0]        cm_r;
  logic [IDX_W-1:0]        p1_r, p2_r, base_r;
  logic [4:0]              cand_r, cend_r;
  logic [2:0]              k_r;
  logic signed [VAL_W-1:0] best_r;
  logic                    pend_v_r;
  logic [IDX_W-1:0]        pend_idx_r;
  logic signed [VAL_W-1:0] pend_val_r;

  // output registers
  logic                    out_valid_r, out_found_r, out_last_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic [1:0]              out_dim_r;
  logic signed [VAL_W-1:0] out_val_r;

  // voxel memory
  logic [VAL_W-1:0]  vox_mem [STORE_DEPTH];
  logic [VAL_W-1:0]  mem_rd_r;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;

  logic              accept, q_accept;
  logic [SIZE_W-1:0] sx_c, sy_c, sz_c;
  logic              div_go, div_done;
  logic [IDX_W-1:0]  div_dividend, div_quo;
  logic [SIZE_W-1:0] div_divisor, div_rem;
  cand_t             cand;
  logic [5:0]        voff;
  logic [CRD_W-1:0]  px, py, pz;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic signed [VAL_W-1:0] rd_val, fin_best;
  logic              qualify;
  logic [IDX_W-1:0]  dec_amt, typ_amt, coface_idx;
  logic [4:0]        start_c, cnt_c;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    if (s == '0) return SIZE_W'(1);
    if (s > SIZE_W'(MAX_SIDE)) return SIZE_W'(MAX_SIDE);
    return s;
  endfunction

  function automatic logic [ADDR_W-1:0] grid_addr(input logic [CRD_W-1:0] x,
                                                  input logic [CRD_W-1:0] y,
                                                  input logic [CRD_W-1:0] z);
    logic [ADDR_W-1:0] xy;
    xy = ADDR_W'(x) * ADDR_W'(PADDED) + ADDR_W'(y);
    return xy * ADDR_W'(PADDED) + ADDR_W'(z);
  endfunction

  assign busy      = state_r != S_IDLE;
  assign accept    = start && !busy;
  assign q_accept  = accept && in_operation == OP_QUERY;
  assign cfg_ready = 1'b1;

  assign sx_c = clamp_size(size_x_r);
  assign sy_c = clamp_size(size_y_r);
  assign sz_c = clamp_size(size_z_r);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_W'(32);
      size_y_r <= SIZE_W'(32);
      size_z_r <= SIZE_W'(32);
      thr_r    <= 32'sh7FFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIZE_X:    size_x_r <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y:    size_y_r <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z:    size_z_r <= cfg_data[SIZE_W-1:0];
        REG_THRESHOLD: thr_r    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // shared divider: idx/sx, then /sy, then /sz
  always_comb begin
    div_go       = 1'b0;
    div_dividend = in_cell_index;
    div_divisor  = sx_c;
    if (q_accept) begin
      div_go = 1'b1;
    end else if (state_r == S_DIV && div_done && phase_r != 2'd2) begin
      div_go       = 1'b1;
      div_dividend = div_quo;
      div_divisor  = (phase_r == 2'd0) ? sy_r : sz_r;
    end
  end

  ccf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // read address for the current candidate's voxel
  assign cand = cand_lookup(cand_r);
  assign voff = cand.vox[k_r[1:0]];
  assign px   = cx_r + CRD_W'(voff[5:4]);
  assign py   = cy_r + CRD_W'(voff[3:2]);
  assign pz   = cz_r + CRD_W'(voff[1:0]);
  assign rd_addr = grid_addr(px, py, pz);
  assign wr_addr = grid_addr(in_grid_x, in_grid_y, in_grid_z);

  assign mem_we = accept && in_operation == OP_WRITE &&
                  in_grid_x < CRD_W'(PADDED) && in_grid_y < CRD_W'(PADDED) &&
                  in_grid_z < CRD_W'(PADDED);
  assign mem_addr = mem_we ? wr_addr : rd_addr;

  // single-port voxel store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) vox_mem[mem_addr] <= in_voxel_value;
    mem_rd_r <= vox_mem[mem_addr];
  end

  // candidate evaluation
  assign rd_val   = mem_rd_r;
  assign fin_best = (rd_val > best_r) ? rd_val : best_r;
  assign qualify  = fin_best != thr_r;

  always_comb begin
    case (cand.dec)
      DEC_X:   dec_amt = IDX_W'(1);
      DEC_Y:   dec_amt = IDX_W'(sx_r);
      DEC_Z:   dec_amt = IDX_W'(sxy_r);
      default: dec_amt = '0;
    endcase
    case (cand.typ)
      2'd1:    typ_amt = sxyz_r;
      2'd2:    typ_amt = {sxyz_r[IDX_W-2:0], 1'b0};
      default: typ_amt = '0;
    endcase
  end
  assign coface_idx = base_r - dec_amt + typ_amt;

  // candidate range for the cell's dimension and type
  always_comb begin
    start_c = '0;
    cnt_c   = '0;
    if (dim_r == 2'd0) begin
      cnt_c = 5'd6;
    end else if (dim_r == 2'd1 && cm_r <= IDX_W'(2)) begin
      start_c = 5'd6 + {cm_r[2:0], 2'b00};
      cnt_c   = 5'd4;
    end else if (dim_r == 2'd2 && cm_r <= IDX_W'(2)) begin
      start_c = 5'd18 + {2'b00, cm_r[1:0], 1'b0};
      cnt_c   = 5'd2;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_accept) state_nxt = S_DIV;
      S_DIV:  if (div_done && phase_r == 2'd2) state_nxt = S_BASE;
      S_BASE: state_nxt = S_SUM;
      S_SUM:  state_nxt = (cand_r == cend_r) ? S_FIN : S_RD;
      S_RD:   if (k_r == 3'd4 && cand_r + 5'd1 == cend_r) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      phase_r     <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          phase_r  <= '0;
          pend_v_r <= 1'b0;
        end
        S_DIV: if (div_done) phase_r <= phase_r + 2'd1;
        S_SUM:  k_r <= '0;
        S_RD: begin
          if (k_r == 3'd4) begin
            k_r <= '0;
            if (qualify) begin
              pend_v_r <= 1'b1;
              if (pend_v_r) out_valid_r <= 1'b1;
            end
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          pend_v_r    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_accept) begin
      sx_r   <= sx_c;
      sy_r   <= sy_c;
      sz_r   <= sz_c;
      sxy_r  <= 12'(sx_c * sy_c);
      idx_r  <= in_cell_index;
      dim_r  <= in_cell_dim;
      cval_r <= in_cell_value;
    end
    if (state_r == S_DIV) begin
      sxyz_r <= IDX_W'(sxy_r * sz_r);
      if (div_done) begin
        case (phase_r)
          2'd0:    cx_r <= div_rem;
          2'd1:    cy_r <= div_rem;
          default: begin
            cz_r <= div_rem;
            cm_r <= div_quo;
          end
        endcase
      end
    end
    if (state_r == S_BASE) begin
      p1_r   <= IDX_W'(sx_r * cy_r);
      p2_r   <= IDX_W'(sxy_r * cz_r);
      cand_r <= start_c;
      cend_r <= start_c + cnt_c;
    end
    if (state_r == S_SUM) base_r <= IDX_W'(cx_r) + p1_r + p2_r;
    if (state_r == S_RD) begin
      // best of cell value and the voxels read so far
      if (k_r == 3'd0) best_r <= cval_r;
      else if (k_r != 3'd4) best_r <= fin_best;
      if (k_r == 3'd4) begin
        cand_r <= cand_r + 5'd1;
        if (qualify) begin
          pend_idx_r <= coface_idx;
          pend_val_r <= fin_best;
          out_found_r <= 1'b1;
          out_idx_r   <= pend_idx_r;
          out_dim_r   <= dim_r + 2'd1;
          out_val_r   <= pend_val_r;
          out_last_r  <= 1'b0;
        end
      end
    end
    if (state_r == S_FIN) begin
      out_last_r  <= 1'b1;
      out_found_r <= pend_v_r;
      out_idx_r   <= pend_v_r ? pend_idx_r : '0;
      out_dim_r   <= pend_v_r ? dim_r + 2'd1 : 2'd0;
      out_val_r   <= pend_v_r ? pend_val_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_coface_index = out_idx_r;
  assign out_coface_dim   = out_dim_r;
  assign out_coface_value = out_val_r;
  assign out_last         = out_last_r;

  // the closing beat of a query lands with the block idle again
  `CCF_ASSERT_IMPLY(a_last_idle, out_valid && out_last, !busy)
  // an empty answer is always the only and final beat
  `CCF_ASSERT_IMPLY(a_empty_last, out_valid && !out_found, out_last)
  // a grid write produces no beat
  `CCF_ASSERT_NEXT(a_write_silent, start && !busy && in_operation == OP_WRITE, !out_valid)

endmodule

// ===== verif/ccf_checker.sv =====
// Checker for the cubical coface enumerator: mirrors the voxel store and the
// registers, predicts the coface beats of each query and compares them.
// Depends on ccf_pkg for widths, operation codes and register indexes.
`timescale 1ns / 100ps
module ccf_checker import ccf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    in_operation,
  input  logic [CRD_W-1:0]        in_grid_x,
  input  logic [CRD_W-1:0]        in_grid_y,
  input  logic [CRD_W-1:0]        in_grid_z,
  input  logic signed [VAL_W-1:0] in_voxel_value,
  input  logic [IDX_W-1:0]        in_cell_index,
  input  logic [1:0]              in_cell_dim,
  input  logic signed [VAL_W-1:0] in_cell_value,
  input  logic                    out_valid,
  input  logic                    out_found,
  input  logic [IDX_W-1:0]        out_coface_index,
  input  logic [1:0]              out_coface_dim,
  input  logic signed [VAL_W-1:0] out_coface_value,
  input  logic                    out_last,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [VAL_W-1:0]        cfg_data,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic                    found;
    logic [IDX_W-1:0]        idx;
    logic [1:0]              dim;
    logic signed [VAL_W-1:0] val;
    logic                    last;
  } coface_t;

  coface_t                 coface_q[$];
  logic signed [VAL_W-1:0] voxel_mirror [STORE_DEPTH];
  logic [SIZE_W-1:0]       size_x, size_y, size_z;
  logic signed [VAL_W-1:0] thr;

  // candidate walk: lowered axis, coface type, four added voxels as octal {x,y,z}
  logic [1:0]  step_dec [24] = '{DEC_NONE, DEC_Z, DEC_NONE, DEC_Y, DEC_NONE, DEC_X,
                                 DEC_NONE, DEC_Z, DEC_NONE, DEC_Y,
                                 DEC_NONE, DEC_Z, DEC_NONE, DEC_X,
                                 DEC_NONE, DEC_Y, DEC_NONE, DEC_X,
                                 DEC_NONE, DEC_Z, DEC_NONE, DEC_Y, DEC_NONE, DEC_X};
  int          step_typ [24] = '{2, 2, 1, 1, 0, 0, 1, 1, 0, 0, 2, 2, 0, 0, 2, 2, 1, 1,
                                 0, 0, 0, 0, 0, 0};
  logic [35:0] step_vox [24] = '{
    36'o112_112_112_112, 36'o110_110_110_110, 36'o121_121_121_121,
    36'o101_101_101_101, 36'o211_211_211_211, 36'o011_011_011_011,
    36'o112_212_112_112, 36'o110_210_110_110, 36'o121_221_121_121,
    36'o101_201_101_101, 36'o112_122_112_112, 36'o110_120_110_110,
    36'o211_221_211_211, 36'o011_021_011_011, 36'o121_122_121_121,
    36'o101_102_101_101, 36'o211_212_211_211, 36'o011_012_011_011,
    36'o112_212_122_222, 36'o110_210_120_220, 36'o121_221_122_222,
    36'o101_201_102_202, 36'o211_221_212_222, 36'o011_021_012_022};

  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_SIDE) return MAX_SIDE;
    return s;
  endfunction

  // offset of voxel k along axis a (0 x, 1 y, 2 z) for candidate i
  function automatic int unsigned vox_off(input int i, input int k, input int a);
    return step_vox[i][(11 - (3 * k + a)) * 3 +: 3];
  endfunction

  task automatic predict_cofaces(input logic [IDX_W-1:0] idx, input logic [1:0] dim,
                                 input logic signed [VAL_W-1:0] cval);
    int unsigned sx, sy, sz, sxy, sxyz, cx, cy, cz, cm, x, y, z, ci, a;
    int first, cnt, n;
    logic signed [VAL_W-1:0] best, v;
    coface_t c;
    sx = eff_size(size_x);
    sy = eff_size(size_y);
    sz = eff_size(size_z);
    sxy = sx * sy;
    sxyz = sxy * sz;
    cx = idx % sx;
    cy = (idx / sx) % sy;
    cz = (idx / sxy) % sz;
    cm = idx / sxyz;
    first = 0;
    cnt = 0;
    n = 0;
    if (dim == 0) begin
      cnt = 6;
    end else if (dim == 1 && cm <= 2) begin
      first = 6 + 4 * cm;
      cnt = 4;
    end else if (dim == 2 && cm <= 2) begin
      first = 18 + 2 * cm;
      cnt = 2;
    end
    for (int i = first; i < first + cnt; i++) begin
      best = cval;
      for (int k = 0; k < 4; k++) begin
        a = ((cx + vox_off(i, k, 0)) * PADDED + cy + vox_off(i, k, 1)) * PADDED
            + cz + vox_off(i, k, 2);
        v = voxel_mirror[a];
        if (v > best) best = v;
      end
      if (best == thr) continue;
      x = cx;
      y = cy;
      z = cz;
      if (step_dec[i] == DEC_X) x = x - 1;
      else if (step_dec[i] == DEC_Y) y = y - 1;
      else if (step_dec[i] == DEC_Z) z = z - 1;
      ci = x + sx * y + sxy * z + sxyz * step_typ[i];
      c.found = 1'b1;
      c.idx = ci[IDX_W-1:0];
      c.dim = dim + 2'd1;
      c.val = best;
      c.last = 1'b0;
      coface_q.push_back(c);
      n++;
    end
    if (n == 0) begin
      c = '0;
      c.last = 1'b1;
      coface_q.push_back(c);
    end else begin
      coface_q[coface_q.size() - 1].last = 1'b1;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    coface_t got, want;
    if (!rst_n) begin
      size_x <= 6'd32;
      size_y <= 6'd32;
      size_z <= 6'd32;
      thr <= 32'sh7FFFFFFF;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SIZE_X:    size_x <= cfg_data[SIZE_W-1:0];
          REG_SIZE_Y:    size_y <= cfg_data[SIZE_W-1:0];
          REG_SIZE_Z:    size_z <= cfg_data[SIZE_W-1:0];
          REG_THRESHOLD: thr <= cfg_data;
          default: ;
        endcase
      end
      // accepted input beat
      if (start && !busy) begin
        if (in_operation == OP_WRITE) begin
          if (in_grid_x < PADDED && in_grid_y < PADDED && in_grid_z < PADDED)
            voxel_mirror[(in_grid_x * PADDED + in_grid_y) * PADDED + in_grid_z] =
              in_voxel_value;
        end else begin
          predict_cofaces(in_cell_index, in_cell_dim, in_cell_value);
        end
      end
      // result beat
      if (out_valid) begin
        got = {out_found, out_coface_index, out_coface_dim, out_coface_value, out_last};
        if (coface_q.size() == 0) begin
          $display("%0t: unexpected coface beat found=%0b idx=%0d dim=%0d val=%0d last=%0b",
                   $time, got.found, got.idx, got.dim, got.val, got.last);
          fail_count++;
        end else begin
          want = coface_q.pop_front();
          if (got !== want) begin
            $display("%0t: coface mismatch expected found=%0b idx=%0d dim=%0d val=%0d last=%0b",
                     $time, want.found, want.idx, want.dim, want.val, want.last);
            $display("%0t:                   actual found=%0b idx=%0d dim=%0d val=%0d last=%0b",
                     $time, got.found, got.idx, got.dim, got.val, got.last);
            fail_count++;
          end
        end
      end
      pending = coface_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the cubical coface enumerator: makes voxel writes,
// queries and register writes, and gives the verdict from ccf_checker.
// Depends on ccf_pkg, ccf_checker and the block itself.
`timescale 1ns / 100ps
module tb_top;
  import ccf_pkg::*;

  logic                    clk, rst_n, start, busy;
  logic                    in_operation;
  logic [CRD_W-1:0]        in_grid_x, in_grid_y, in_grid_z;
  logic signed [VAL_W-1:0] in_voxel_value, in_cell_value;
  logic [IDX_W-1:0]        in_cell_index;
  logic [1:0]              in_cell_dim;
  logic                    out_valid, out_found, out_last;
  logic [IDX_W-1:0]        out_coface_index;
  logic [1:0]              out_coface_dim;
  logic signed [VAL_W-1:0] out_coface_value;
  logic                    cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [VAL_W-1:0]        cfg_data;
  int                      fail_count, pending;

  cubical_coface_enumerator u_top (.*);
  ccf_checker u_checker (.*);

  // voxels written so far, so that no query reads an unwritten entry
  bit                      written [STORE_DEPTH];
  int unsigned             sx = 32, sy = 32, sz = 32;
  logic signed [VAL_W-1:0] thr = 32'sh7FFFFFFF;
  int                      burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("cubical_coface_enumerator test failed");
    $finish;
  end

  function automatic int unsigned clamp_side(input logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_SIDE) return MAX_SIDE;
    return s;
  endfunction

  // mix of threshold hits, close ties, extremes and full-range values
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return thr;
    if (r < 45) return $signed($urandom_range(0, 8)) - 4;
    if (r < 50) return 32'sh7FFFFFFF;
    if (r < 55) return 32'sh80000000;
    return $urandom;
  endfunction

  // one input beat; called at a falling edge, returns at a falling edge
  task automatic send_beat(input logic op, input int gx, input int gy, input int gz,
                           input logic signed [VAL_W-1:0] vv, input logic [IDX_W-1:0] idx,
                           input logic [1:0] dim, input logic signed [VAL_W-1:0] cv);
    in_operation <= op;
    in_grid_x <= gx;
    in_grid_y <= gy;
    in_grid_z <= gz;
    in_voxel_value <= vv;
    in_cell_index <= idx;
    in_cell_dim <= dim;
    in_cell_value <= cv;
    start <= 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic write_voxel(input int gx, input int gy, input int gz,
                             input logic signed [VAL_W-1:0] vv);
    send_beat(OP_WRITE, gx, gy, gz, vv, $urandom, $urandom, $urandom);
    if (gx < PADDED && gy < PADDED && gz < PADDED)
      written[(gx * PADDED + gy) * PADDED + gz] = 1'b1;
  endtask

  // make sure the 3x3x3 padded block read by a query is written
  task automatic fill_block(input int unsigned cx, input int unsigned cy,
                            input int unsigned cz, input bit all_thr);
    int unsigned x, y, z;
    bit border;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        for (int c = 0; c < 3; c++) begin
          x = cx + a;
          y = cy + b;
          z = cz + c;
          border = x == 0 || y == 0 || z == 0 || x == sx + 1 || y == sy + 1 || z == sz + 1;
          if (all_thr)
            write_voxel(x, y, z, thr);
          else if (!written[(x * PADDED + y) * PADDED + z])
            write_voxel(x, y, z,
                        (border && $urandom_range(0, 9) < 8) ? thr : pick_value());
        end
  endtask

  task automatic query_cell(input logic [IDX_W-1:0] idx, input logic [1:0] dim,
                            input logic signed [VAL_W-1:0] cv, input bit all_thr);
    fill_block(idx % sx, (idx / sx) % sy, (idx / (sx * sy)) % sz, all_thr);
    send_beat(OP_QUERY, $urandom, $urandom, $urandom, $urandom, idx, dim, cv);
  endtask

  // let all coface beats drain; every write has already been accepted by then
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [VAL_W-1:0] data);
    drain();
    cfg_index <= ri;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (ri)
      REG_SIZE_X:    sx = clamp_side(data[SIZE_W-1:0]);
      REG_SIZE_Y:    sy = clamp_side(data[SIZE_W-1:0]);
      REG_SIZE_Z:    sz = clamp_side(data[SIZE_W-1:0]);
      REG_THRESHOLD: thr = data;
      default: ;
    endcase
  endtask

  task automatic random_items(input int n);
    int r;
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        idx = (r < 55) ? $urandom_range(0, sx * sy * sz * 3 - 1) : $urandom;
        query_cell(idx, $urandom, pick_value(), r < 4);
      end else if (r < 90) begin
        write_voxel($urandom_range(0, sx + 1), $urandom_range(0, sy + 1),
                    $urandom_range(0, sz + 1), pick_value());
      end else begin
        // outside the padded grid: ignored by the block
        write_voxel($urandom_range(PADDED, 63), $urandom, $urandom, $urandom);
      end
    end
  endtask

  // size and threshold settings per phase
  logic [SIZE_W-1:0] ph_x [6] = '{6'd1, 6'd0, 6'd63, 6'd2, 6'd5, 6'd32};
  logic [SIZE_W-1:0] ph_y [6] = '{6'd1, 6'd0, 6'd40, 6'd3, 6'd32, 6'd2};
  logic [SIZE_W-1:0] ph_z [6] = '{6'd1, 6'd0, 6'd33, 6'd4, 6'd1, 6'd7};
  logic [VAL_W-1:0]  ph_t [6] = '{32'h80000000, 32'h0, 32'h7FFFFFFF, 32'h0001_8000,
                                  32'hFFFF_0000, 32'h7FFFFFFF};

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_WRITE;
    in_grid_x = '0;
    in_grid_y = '0;
    in_grid_z = '0;
    in_voxel_value = '0;
    in_cell_index = '0;
    in_cell_dim = '0;
    in_cell_value = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SIZE_X;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: every dimension, index and value extremes, low border,
    // types without cofaces, nothing qualifying, ignored writes
    query_cell(0, 0, 32'sh80000000, 0);
    query_cell(0, 1, 32'sh7FFFFFFF, 0);
    query_cell(0, 2, 0, 0);
    query_cell(0, 3, 5, 0);
    query_cell(17'h1FFFF, 0, 1, 0);
    query_cell(17'h1FFFF, 1, 1, 0);
    query_cell(98303, 1, -1, 0);
    query_cell(98303, 2, -1, 0);
    query_cell(32768 * 2 + 33 + 1024, 1, 3, 0);
    query_cell(32768 * 2 + 33 + 1024, 2, 3, 0);
    query_cell(32768 + 31 + 31 * 32 + 31 * 1024, 1, 0, 0);
    query_cell(32768 + 5, 2, 0, 0);
    query_cell(100, 0, thr, 1);
    query_cell(100, 2, 32'sh80000000, 1);
    write_voxel(63, 63, 63, 32'sh5A5A5A5A);
    write_voxel(34, 0, 0, -1);
    write_voxel(33, 33, 33, thr);
    query_cell(31 + 31 * 32 + 31 * 1024, 0, 32'sh80000000, 0);
    random_items(40);

    foreach (ph_x[p]) begin
      write_reg(REG_SIZE_X, ph_x[p]);
      write_reg(REG_SIZE_Y, ph_y[p]);
      write_reg(REG_SIZE_Z, ph_z[p]);
      write_reg(REG_THRESHOLD, ph_t[p]);
      query_cell(0, 0, thr, 0);
      query_cell(0, 1, 32'sh80000000, 0);
      random_items(50);
    end

    drain();
    if (fail_count == 0)
      $display("cubical_coface_enumerator test passed");
    else
      $display("cubical_coface_enumerator test failed");
    $finish;
  end

endmodule
